/* hdl/matrix_add_sub_multiply_core_defines.svh */
// Assertion macros shared by the matrix core RTL.
// Each use needs clk and rst in scope; no other dependencies.
`ifndef MATRIX_ADD_SUB_MULTIPLY_CORE_DEFINES_SVH
`define MATRIX_ADD_SUB_MULTIPLY_CORE_DEFINES_SVH

// Plain property checked on every clock outside reset
`define MASM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication checked outside reset
`define MASM_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* hdl/masm_pkg.sv */
// Shared types and codes for the matrix add/subtract/multiply core.
// No dependencies; imported by the sequencer and the top level.
package masm_pkg;

  // field widths of the stream items
  localparam int IDX_W     = 3;
  localparam int VAL_W     = 32;
  localparam int FUNC_W    = 2;
  localparam int TDATA_W   = 40;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 4;

  // input selector codes
  localparam logic [FUNC_W-1:0] FUNC_WR_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN  = 2'd2;

  // operation codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B  = 3'd4;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // result status
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [1:0]       op_mode;
    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] cols_a;
    logic [DIM_W-1:0] rows_b;
    logic [DIM_W-1:0] cols_b;
  } masm_cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             status;
    logic             last;
  } masm_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_DATA,
    ST_MUL,
    ST_EMIT,
    ST_ERR
  } masm_state_t;

endpackage

/* hdl/masm_store.sv */
// Matrix element store: one write port, one read port, registered read.
// No dependencies; instantiated once for each operand matrix.
module masm_store #(
  parameter int DEPTH = 64,
  parameter int DATA_WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/masm_mul.sv */
// Multi-cycle multiplier giving the low DATA_WIDTH bits of a product.
// Works in 32-bit partial products, one per cycle; no dependencies.
module masm_mul #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] p
);

  localparam int NCH  = (DATA_WIDTH + 31) / 32;
  localparam int PADW = NCH * 32;
  localparam int CW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int SW   = CW + 1;

  logic [PADW-1:0] a_pad, b_pad;
  logic            busy, pv, plast;
  logic [CW-1:0]   ci, cj;
  logic [SW-1:0]   sum_c, psh;
  logic [63:0]     prod;
  logic [PADW-1:0] acc, term;
  logic            fin_pair, fin_all;

  assign a_pad = PADW'(a);
  assign b_pad = PADW'(b);

  // only chunk pairs below the result width contribute
  assign sum_c    = SW'(ci) + SW'(cj);
  assign fin_pair = (sum_c == SW'(NCH - 1));
  assign fin_all  = fin_pair && (ci == CW'(NCH - 1));
  assign term     = PADW'(prod) << (32 * psh);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
    end else begin
      pv   <= busy;
      done <= pv && plast;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && fin_all) begin
        busy <= 1'b0;
      end
    end
  end

  // partial products and accumulation
  always_ff @(posedge clk) begin
    if (pv) begin
      acc <= acc + term;
    end
    if (start) begin
      ci  <= '0;
      cj  <= '0;
      acc <= '0;
    end else if (busy) begin
      prod  <= a_pad[32*ci +: 32] * b_pad[32*cj +: 32];
      psh   <= sum_c;
      plast <= fin_all;
      if (fin_pair) begin
        ci <= ci + CW'(1);
        cj <= '0;
      end else begin
        cj <= cj + CW'(1);
      end
    end
  end

  assign p = acc[DATA_WIDTH-1:0];

endmodule

/* hdl/masm_seq.sv */
// Run sequencer: walks the stores element by element, accumulates, and
// holds the output item register. Depends on masm_pkg and the defines.
`include "matrix_add_sub_multiply_core_defines.svh"

module masm_seq #(
  parameter int MAX_DIM = 8,
  parameter int DATA_WIDTH = 32,
  localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  masm_pkg::masm_cfg_t   cfg,
  input  logic                  run,
  output logic                  idle,
  output logic [AW-1:0]         raddr_a,
  output logic [AW-1:0]         raddr_b,
  input  logic [DATA_WIDTH-1:0] rdata_a,
  input  logic [DATA_WIDTH-1:0] rdata_b,
  output logic                  mul_start,
  input  logic                  mul_done,
  input  logic [DATA_WIDTH-1:0] mul_p,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output masm_pkg::masm_res_t   res
);
  import masm_pkg::*;

  localparam int XW = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

  masm_state_t           state, state_next;
  logic [DIM_W-1:0]      i, j, k, i_next, j_next, k_next;
  logic [DIM_W-1:0]      nr, nc, col_a, row_b;
  logic [DATA_WIDTH-1:0] acc, acc_next;
  logic [XW-1:0]         acc_ext;
  logic                  is_mul, cfg_ok, shape_ok, dims_ok, out_free, out_load, is_last;
  masm_res_t             res_next;

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    return (d != '0) && (32'(d) <= 32'(MAX_DIM));
  endfunction

  // size check done at run start
  assign is_mul  = (cfg.op_mode == OP_MUL);
  assign dims_ok = dim_ok(cfg.rows_a) && dim_ok(cfg.cols_a) &&
                   dim_ok(cfg.rows_b) && dim_ok(cfg.cols_b);
  always_comb begin
    case (cfg.op_mode)
      OP_ADD, OP_SUB: shape_ok = (cfg.rows_a == cfg.rows_b) && (cfg.cols_a == cfg.cols_b);
      OP_MUL:         shape_ok = (cfg.cols_a == cfg.rows_b);
      default:        shape_ok = 1'b0;
    endcase
  end
  assign cfg_ok = dims_ok && shape_ok;

  assign nr = cfg.rows_a;
  assign nc = is_mul ? cfg.cols_b : cfg.cols_a;

  // store addresses follow the loop counters
  assign col_a   = is_mul ? k : j;
  assign row_b   = is_mul ? k : i;
  assign raddr_a = AW'(32'(i) * MAX_DIM + 32'(col_a));
  assign raddr_b = AW'(32'(row_b) * MAX_DIM + 32'(j));

  assign out_free = !m_tvalid || m_tready;
  assign is_last  = ((i + 4'd1) == nr) && ((j + 4'd1) == nc);
  assign acc_ext  = XW'($signed(acc));
  assign idle     = (state == ST_IDLE);

  // next state and datapath control
  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    acc_next   = acc;
    mul_start  = 1'b0;
    out_load   = 1'b0;
    res_next   = res;
    case (state)
      ST_IDLE: begin
        if (run) begin
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
          acc_next   = '0;
          state_next = cfg_ok ? ST_ADDR : ST_ERR;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_load   = 1'b1;
          res_next   = '{row: '0, col: '0, value: '0, status: STATUS_ERR, last: 1'b1};
          state_next = ST_IDLE;
        end
      end
      ST_ADDR: begin
        state_next = ST_DATA;
      end
      ST_DATA: begin
        if (is_mul) begin
          mul_start  = 1'b1;
          state_next = ST_MUL;
        end else begin
          acc_next   = (cfg.op_mode == OP_ADD) ? rdata_a + rdata_b : rdata_a - rdata_b;
          state_next = ST_EMIT;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          acc_next = acc + mul_p;
          if ((k + 4'd1) == cfg.cols_a) begin
            state_next = ST_EMIT;
          end else begin
            k_next     = k + 4'd1;
            state_next = ST_ADDR;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          res_next = '{row: i[IDX_W-1:0], col: j[IDX_W-1:0], value: acc_ext[VAL_W-1:0],
                       status: STATUS_OK, last: is_last};
          k_next   = '0;
          acc_next = '0;
          if (is_last) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_ADDR;
            if ((j + 4'd1) == nc) begin
              j_next = '0;
              i_next = i + 4'd1;
            end else begin
              j_next = j + 4'd1;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // counters, accumulator, output item
  always_ff @(posedge clk) begin
    i   <= i_next;
    j   <= j_next;
    k   <= k_next;
    acc <= acc_next;
    res <= res_next;
  end

  `MASM_IMPLY(a_run_idle, run, state == ST_IDLE, "run item taken while busy")
  `MASM_IMPLY(a_mul_wait, mul_done, state == ST_MUL, "product arrived outside multiply step")
  `MASM_ASSERT(a_err_last, !(m_tvalid && res.status == STATUS_ERR && !res.last), "error item without last")

endmodule

/* hdl/matrix_add_sub_multiply_core.sv */
// Top level of the integer matrix add/subtract/multiply core.
// Depends on masm_pkg, masm_store, masm_mul and masm_seq.
//
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      tuser func, tdata row/col/value
//  m_*       out  tvalid/tready      tdata row/col/value, tuser status, tlast
//  cfg_*     in   cfg_we             cfg_index, cfg_data
//
// Element writes are accepted while the core is idle; s_tready drops for the
// length of a run. A size error yields a single error item with tlast set.
// Multiply accumulates cols_a products per result element through the shared
// 32x32 multiplier, one partial product up to 32-bit data and three for 33- to
// 64-bit data. A stalled m_tready holds the run at its next element. rst is
// synchronous; the stores have no reset.
module matrix_add_sub_multiply_core #(
  parameter int MAX_DIM = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [masm_pkg::TDATA_W-1:0]         s_tdata,   // row, col, value
  input  logic [masm_pkg::FUNC_W-1:0]          s_tuser,   // func
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [masm_pkg::TDATA_W-1:0]         m_tdata,   // out_row, out_col, out_value
  output logic                                 m_tuser,   // status
  output logic                                 m_tlast,
  input  logic                                 cfg_we,
  input  logic [masm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [masm_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import masm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

  masm_cfg_t             cfg;
  masm_res_t             res;
  logic                  in_take, run, idle, wr_ok, we_a, we_b;
  logic [IDX_W-1:0]      in_row, in_col;
  logic [VAL_W-1:0]      in_value;
  logic [XW-1:0]         vext;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AW-1:0]         waddr, raddr_a, raddr_b;
  logic [DATA_WIDTH-1:0] rdata_a, rdata_b, mul_p;
  logic                  mul_start, mul_done;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{op_mode: OP_MUL, rows_a: DIM_RESET, cols_a: DIM_RESET,
               rows_b: DIM_RESET, cols_b: DIM_RESET};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OP_MODE: cfg.op_mode <= cfg_data[1:0];
        CFG_ROWS_A:  cfg.rows_a  <= cfg_data;
        CFG_COLS_A:  cfg.cols_a  <= cfg_data;
        CFG_ROWS_B:  cfg.rows_b  <= cfg_data;
        CFG_COLS_B:  cfg.cols_b  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input item decode; writes land before any later run reads them
  assign in_row   = s_tdata[IDX_W-1:0];
  assign in_col   = s_tdata[2*IDX_W-1:IDX_W];
  assign in_value = s_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
  assign s_tready = idle;
  assign in_take  = s_tvalid && s_tready;
  assign wr_ok    = (32'(in_row) < 32'(MAX_DIM)) && (32'(in_col) < 32'(MAX_DIM));
  assign we_a     = in_take && wr_ok && (s_tuser == FUNC_WR_A);
  assign we_b     = in_take && wr_ok && (s_tuser == FUNC_WR_B);
  assign run      = in_take && (s_tuser == FUNC_RUN);
  assign waddr    = AW'(32'(in_row) * MAX_DIM + 32'(in_col));
  assign vext     = XW'($signed(in_value));
  assign wdata    = vext[DATA_WIDTH-1:0];

  masm_store #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  masm_store #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  masm_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (rdata_a),
    .b     (rdata_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  masm_seq #(.MAX_DIM(MAX_DIM), .DATA_WIDTH(DATA_WIDTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .run       (run),
    .idle      (idle),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b),
    .mul_start (mul_start),
    .mul_done  (mul_done),
    .mul_p     (mul_p),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .res       (res)
  );

  // output item packing
  assign m_tdata = TDATA_W'({res.value, res.col, res.row});
  assign m_tuser = res.status;
  assign m_tlast = res.last;

endmodule

/* tb/tb.sv */
// Self-checking testbench for matrix_add_sub_multiply_core: loads A and B, runs add,
// subtract and multiply, and checks every result element against an internal predictor.
// Depends on masm_pkg and the core RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import masm_pkg::*;

  localparam int DIM        = 8;
  localparam int RAND_ITEMS = 380;
  localparam int SETTLE     = 8;
  localparam int TAIL       = 20;
  localparam int LIMIT      = 5_000_000;
  localparam int HOLD_LEN   = 300;
  localparam int MAX_PRINT  = 50;

  // codes the package leaves unnamed
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam logic [1:0]        OP_NONE   = 2'd3;

  // Scoreboard: mirrors stores and registers, queues expected result elements
  class matrix_result_board;
    logic [VAL_W-1:0] a_mem [DIM*DIM];
    logic [VAL_W-1:0] b_mem [DIM*DIM];
    bit               a_set [DIM*DIM];
    bit               b_set [DIM*DIM];
    logic [1:0]       op_mode;
    logic [DIM_W-1:0] rows_a, cols_a, rows_b, cols_b;
    masm_res_t        expected_elems[$];
    int               mismatches;
    int               elems_checked;
    int               runs;
    int               error_runs;

    function void reset_state();
      foreach (a_set[i]) begin
        a_set[i] = 1'b0;
        b_set[i] = 1'b0;
      end
      op_mode = OP_MUL;
      rows_a  = DIM_RESET;
      cols_a  = DIM_RESET;
      rows_b  = DIM_RESET;
      cols_b  = DIM_RESET;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_OP_MODE: op_mode = data[1:0];
        CFG_ROWS_A:  rows_a  = data;
        CFG_COLS_A:  cols_a  = data;
        CFG_ROWS_B:  rows_b  = data;
        CFG_COLS_B:  cols_b  = data;
        default: ;
      endcase
    endfunction

    function bit dim_ok(logic [DIM_W-1:0] d);
      return d >= 1 && d <= DIM;
    endfunction

    // true when a run item produces a full matrix rather than the error element
    function bit sizes_fit();
      if (!(dim_ok(rows_a) && dim_ok(cols_a) && dim_ok(rows_b) && dim_ok(cols_b)))
        return 1'b0;
      case (op_mode)
        OP_ADD, OP_SUB: return rows_a == rows_b && cols_a == cols_b;
        OP_MUL:         return cols_a == rows_b;
        default:        return 1'b0;
      endcase
    endfunction

    // Predict the effect of one accepted item
    function void accept_item(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] row,
                              logic [IDX_W-1:0] col, logic [VAL_W-1:0] value);
      masm_res_t        r;
      logic [VAL_W-1:0] acc;
      int               n_cols;
      case (func)
        FUNC_WR_A: begin
          a_mem[{row, col}] = value;
          a_set[{row, col}] = 1'b1;
        end
        FUNC_WR_B: begin
          b_mem[{row, col}] = value;
          b_set[{row, col}] = 1'b1;
        end
        FUNC_RUN: begin
          runs++;
          if (!sizes_fit()) begin
            error_runs++;
            r.row    = '0;
            r.col    = '0;
            r.value  = '0;
            r.status = STATUS_ERR;
            r.last   = 1'b1;
            expected_elems.push_back(r);
          end else begin
            n_cols = int'((op_mode == OP_MUL) ? cols_b : cols_a);
            for (int i = 0; i < rows_a; i++) begin
              for (int j = 0; j < n_cols; j++) begin
                if (op_mode == OP_MUL) begin
                  // low word of the product sum does not depend on signedness
                  acc = '0;
                  for (int k = 0; k < cols_a; k++)
                    acc = acc + a_mem[i*DIM+k] * b_mem[k*DIM+j];
                end else if (op_mode == OP_ADD) begin
                  acc = a_mem[i*DIM+j] + b_mem[i*DIM+j];
                end else begin
                  acc = a_mem[i*DIM+j] - b_mem[i*DIM+j];
                end
                r.row    = IDX_W'(i);
                r.col    = IDX_W'(j);
                r.value  = acc;
                r.status = STATUS_OK;
                r.last   = (i == rows_a - 1) && (j == n_cols - 1);
                expected_elems.push_back(r);
              end
            end
          end
        end
        default: ;  // unused selector is dropped by the core
      endcase
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINT)
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Compare one received element with the oldest prediction
    task check_element(masm_res_t got);
      masm_res_t want;
      if (expected_elems.size() == 0) begin
        flag_mismatch($sformatf("unexpected element row %0d col %0d value %h status %0b",
                                got.row, got.col, got.value, got.status));
      end else begin
        want = expected_elems.pop_front();
        elems_checked++;
        if (got.row !== want.row)
          flag_mismatch($sformatf("row got %0d want %0d", got.row, want.row));
        if (got.col !== want.col)
          flag_mismatch($sformatf("col got %0d want %0d", got.col, want.col));
        if (got.value !== want.value)
          flag_mismatch($sformatf("value [%0d][%0d] got %h want %h",
                                  want.row, want.col, got.value, want.value));
        if (got.status !== want.status)
          flag_mismatch($sformatf("status got %0b want %0b", got.status, want.status));
        if (got.last !== want.last)
          flag_mismatch($sformatf("last [%0d][%0d] got %0b want %0b",
                                  want.row, want.col, got.last, want.last));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [TDATA_W-1:0]   s_tdata = '0;     // row, col, value
  logic [FUNC_W-1:0]    s_tuser = '0;     // func
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;          // out_row, out_col, out_value
  logic                 m_tuser;          // status
  logic                 m_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  matrix_result_board results = new();

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  quiet_send     = 1'b0;
  int  hold_req       = 0;
  int  hold_left      = 0;
  int  quiet_left     = 0;
  int  items_sent     = 0;
  int  keep_cfg       = 0;
  int  cycles         = 0;
  int  base_items;

  matrix_add_sub_multiply_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d elements outstanding",
               cycles, results.expected_elems.size());
      $display("tb failed");
      $finish;
    end
  end

  // Result side: check accepted elements, then pick next tready
  always @(posedge clk) begin : rx
    masm_res_t got;
    bit        ready_nxt;
    if (!rst && m_tvalid && m_tready) begin
      got.row    = m_tdata[2:0];
      got.col    = m_tdata[5:3];
      got.value  = m_tdata[37:6];
      got.status = m_tuser;
      got.last   = m_tlast;
      results.check_element(got);
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_nxt = 1'b0;
    end else if (quiet_left > 0) begin
      quiet_left--;
      ready_nxt = 1'b1;
    end else begin
      if ($urandom_range(99) < 3)
        quiet_left = $urandom_range(60, 10);
      ready_nxt = $urandom_range(99) >= recv_stall_pct;
    end
    m_tready <= ready_nxt;
  end

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return '0;
      4, 5:    return $urandom_range(200) - 100;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_dim();
    return ($urandom_range(19) == 0) ? DIM : $urandom_range(4, 1);
  endfunction

  // Offer one item, with a random gap first, and wait until it is taken
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value);
    int gap;
    gap = 0;
    if (!quiet_send)
      while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {2'b00, value, col, row};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    results.accept_item(func, row, col, value);
    if (func != FUNC_NONE) items_sent++;
  endtask

  // Stop offering, let every expected element arrive and the core settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (results.expected_elems.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all five registers while the core is idle
  task automatic configure(input int op, input int ra, input int ca, input int rb, input int cb);
    logic [CFG_IDX_W-1:0] regs [5] = '{CFG_OP_MODE, CFG_ROWS_A, CFG_COLS_A, CFG_ROWS_B, CFG_COLS_B};
    int                   vals [5];
    vals = '{op, ra, ca, rb, cb};
    wait_idle();
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i][CFG_DAT_W-1:0];
      @(posedge clk);
      results.write_reg(regs[i], vals[i][CFG_DAT_W-1:0]);
    end
    cfg_we <= 1'b0;
  endtask

  // One job: maybe new sizes, a few element writes, fill what the run reads, then run
  task automatic run_job();
    int               n_extra;
    int               dr, dc;
    logic [IDX_W-1:0] r, c;
    quiet_send = ($urandom_range(3) == 0);
    if (keep_cfg > 0) begin
      keep_cfg--;
    end else if ($urandom_range(99) < 35) begin
      case ($urandom_range(9))
        0:       configure($urandom_range(15), $urandom_range(15), $urandom_range(15),
                           $urandom_range(15), $urandom_range(15));
        1, 2, 3: begin
          dr = pick_dim();
          dc = pick_dim();
          configure($urandom_range(1) ? OP_SUB : OP_ADD, dr, dc, dr, dc);
        end
        default: begin
          dc = pick_dim();
          configure(OP_MUL, pick_dim(), dc, dc, pick_dim());
        end
      endcase
    end
    n_extra = $urandom_range(4);
    repeat (n_extra) begin
      if ($urandom_range(9) == 0) begin
        send_item(FUNC_NONE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
      end else if (results.sizes_fit() && $urandom_range(1)) begin
        // rewrite an element the run will actually read
        if ($urandom_range(1)) begin
          r = IDX_W'($urandom_range(results.rows_a - 1));
          c = IDX_W'($urandom_range(results.cols_a - 1));
          send_item(FUNC_WR_A, r, c, rand_value());
        end else begin
          r = IDX_W'($urandom_range(results.rows_b - 1));
          c = IDX_W'($urandom_range(results.cols_b - 1));
          send_item(FUNC_WR_B, r, c, rand_value());
        end
      end else begin
        send_item($urandom_range(1) ? FUNC_WR_B : FUNC_WR_A, IDX_W'($urandom),
                  IDX_W'($urandom), rand_value());
      end
    end
    // never let a run read an element that was not loaded
    if (results.sizes_fit()) begin
      for (int i = 0; i < results.rows_a; i++)
        for (int j = 0; j < results.cols_a; j++)
          if (!results.a_set[i*DIM+j])
            send_item(FUNC_WR_A, IDX_W'(i), IDX_W'(j), rand_value());
      for (int i = 0; i < results.rows_b; i++)
        for (int j = 0; j < results.cols_b; j++)
          if (!results.b_set[i*DIM+j])
            send_item(FUNC_WR_B, IDX_W'(i), IDX_W'(j), rand_value());
    end
    send_item(FUNC_RUN, IDX_W'($urandom), IDX_W'($urandom), $urandom);
  endtask

  initial begin
    results.reset_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: wraparound on add, subtract and multiply with 1x1 matrices
    configure(OP_ADD, 1, 1, 1, 1);
    send_item(FUNC_WR_A, 0, 0, 32'h7FFF_FFFF);
    send_item(FUNC_WR_B, 0, 0, 32'h0000_0001);
    send_item(FUNC_RUN, 0, 0, 0);
    configure(OP_SUB, 1, 1, 1, 1);
    send_item(FUNC_WR_A, 0, 0, 32'h8000_0000);
    send_item(FUNC_RUN, 0, 0, 0);
    configure(OP_MUL, 1, 1, 1, 1);
    send_item(FUNC_WR_B, 0, 0, 32'hFFFF_FFFF);
    send_item(FUNC_RUN, 7, 7, 32'hFFFF_FFFF);
    // unused selector with every data bit set, then corner positions
    send_item(FUNC_NONE, 7, 7, 32'hFFFF_FFFF);
    send_item(FUNC_WR_A, 7, 7, 32'h7FFF_FFFF);
    send_item(FUNC_WR_B, 7, 7, 32'h8000_0000);
    // every flavor of size error
    configure(OP_ADD, 1, 1, 2, 1);
    send_item(FUNC_RUN, 0, 0, 0);
    configure(OP_MUL, 1, 1, 2, 1);
    send_item(FUNC_RUN, 0, 0, 0);
    configure(OP_NONE, 1, 1, 1, 1);
    send_item(FUNC_RUN, 0, 0, 0);
    configure(OP_MUL, 0, 1, 1, 1);
    send_item(FUNC_RUN, 0, 0, 0);
    configure(OP_ADD, 15, 9, 15, 9);
    send_item(FUNC_RUN, 0, 0, 0);
    // upper bits of the mode write are dropped by the 2-bit register
    configure({2'b11, OP_MUL}, 1, 1, 1, 1);
    send_item(FUNC_RUN, 0, 0, 0);
    wait_idle();

    // Random jobs over four handshake pressure settings
    base_items = items_sent;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          configure(OP_MUL, DIM, DIM, DIM, DIM);
        end
        1: begin
          send_idle_pct = 51; recv_stall_pct = 0;
          configure(OP_ADD, 3, 3, 3, 3);
          // receiver holds off so the run backs up into the input
          hold_req = HOLD_LEN;
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 51;
          configure(OP_SUB, DIM, DIM, DIM, DIM);
        end
        default: begin
          send_idle_pct = 26; recv_stall_pct = 26;
          configure(OP_MUL, DIM, 1, 1, DIM);
        end
      endcase
      keep_cfg = 2;
      while (items_sent - base_items < (ph + 1) * RAND_ITEMS / 4) run_job();
      wait_idle();
    end

    repeat (TAIL) @(posedge clk);
    $display("covered %0d items, %0d runs (%0d size errors), %0d result elements checked",
             items_sent, results.runs, results.error_runs, results.elems_checked);
    $display("handshake settings: free flow, sender gaps, receiver stalls, both; %0d mismatches",
             results.mismatches);
    if (results.mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

/* matrix_add_sub_multiply_core.f */
+incdir+hdl
hdl/masm_pkg.sv
hdl/masm_store.sv
hdl/masm_mul.sv
hdl/masm_seq.sv
hdl/matrix_add_sub_multiply_core.sv
tb/tb.sv
